/* rtl/core/lcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared types and constants for the LED color crossfade cycler.
// ----------------------------------------------------------------------------
package lcc_pkg;

  // channel and index widths
  localparam int CH_W     = 8;
  localparam int WEIGHT_W = 8;
  localparam int CIDX_W   = 3;

  // palette size and the number of entries in the cycle
  localparam int PALETTE_SLOTS = 6;
  localparam int COLOR_COUNT   = 6;

  // fixed-point constants for the weight table
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  // register indexes (byte address / 4)
  localparam logic [CIDX_W-1:0] REG_PALETTE_0 = 3'd0;
  localparam logic [CIDX_W-1:0] REG_PALETTE_1 = 3'd1;
  localparam logic [CIDX_W-1:0] REG_PALETTE_2 = 3'd2;
  localparam logic [CIDX_W-1:0] REG_PALETTE_3 = 3'd3;
  localparam logic [CIDX_W-1:0] REG_PALETTE_4 = 3'd4;
  localparam logic [CIDX_W-1:0] REG_PALETTE_5 = 3'd5;

  // packed palette word: red high, blue low
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef rgb_t [PALETTE_SLOTS-1:0] palette_t;

  localparam rgb_t PALETTE_RESET_0 = 24'h6633CC;
  localparam rgb_t PALETTE_RESET_1 = 24'h0000FF;
  localparam rgb_t PALETTE_RESET_2 = 24'hFF0000;
  localparam rgb_t PALETTE_RESET_3 = 24'h00FF00;
  localparam rgb_t PALETTE_RESET_4 = 24'h00FFFF;
  localparam rgb_t PALETTE_RESET_5 = 24'hFF00FF;

  // palette index plus one, wrapping at the cycle length
  function automatic logic [CIDX_W-1:0] step_index(input logic [CIDX_W-1:0] idx);
    logic [CIDX_W-1:0] res;
    if (idx >= CIDX_W'(COLOR_COUNT - 1)) begin
      res = '0;
    end else begin
      res = idx + CIDX_W'(1);
    end
    return res;
  endfunction

  // palette lookup; entries past the palette read as the first one
  function automatic rgb_t pick_color(input palette_t pal, input logic [CIDX_W-1:0] idx);
    rgb_t res;
    if (idx < CIDX_W'(PALETTE_SLOTS)) begin
      res = pal[idx];
    end else begin
      res = pal[0];
    end
    return res;
  endfunction

endpackage

/* rtl/core/lcc_weight_rom.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_weight_rom
// Raised-cosine fade weight per phase, unsigned Q0.8, built at elaboration.
// ----------------------------------------------------------------------------
module lcc_weight_rom
  import lcc_pkg::*;
#(
  parameter int PERIOD  = 75,
  parameter int PHASE_W = (PERIOD > 1) ? $clog2(PERIOD) : 1
) (
  input  logic [PHASE_W-1:0]  phase,
  output logic [WEIGHT_W-1:0] weight
);

  // constant table, one entry per phase
  logic [WEIGHT_W-1:0] wtab [PERIOD];

  // sin^2(pi*phase/(2*PERIOD)) via a Q30 Taylor series, rounded to Q0.8
  for (genvar g = 0; g < PERIOD; g++) begin : g_wtab
    // angle in q30 and its square
    localparam logic [63:0] ANG  = (PI_Q30 * 64'(g)) / (64'd2 * 64'(PERIOD));
    localparam logic [63:0] ANG2 = (ANG * ANG) >> 30;
    // each term is the previous one times ang^2 over (2k)(2k+1)
    localparam logic [63:0] T1 = ((ANG * ANG2) >> 30) / 64'd6;
    localparam logic [63:0] T2 = ((T1 * ANG2) >> 30) / 64'd20;
    localparam logic [63:0] T3 = ((T2 * ANG2) >> 30) / 64'd42;
    localparam logic [63:0] T4 = ((T3 * ANG2) >> 30) / 64'd72;
    localparam logic [63:0] T5 = ((T4 * ANG2) >> 30) / 64'd110;
    localparam longint SUM = longint'(ANG) - longint'(T1) + longint'(T2)
                           - longint'(T3) + longint'(T4) - longint'(T5);
    // clamp the sine to [0, 1]
    localparam longint SUM_LO = (SUM < longint'(0)) ? longint'(0) : SUM;
    localparam longint SIN_V  = (SUM_LO > longint'(ONE_Q30)) ? longint'(ONE_Q30) : SUM_LO;
    // square to q60, round half up to q0.8, saturate
    localparam logic [63:0] SQ   = 64'(SIN_V) * 64'(SIN_V);
    localparam logic [63:0] WRAW = (SQ + (64'd1 << 51)) >> 52;
    localparam logic [63:0] WSAT = (WRAW > 64'd255) ? 64'd255 : WRAW;
    assign wtab[g] = WSAT[WEIGHT_W-1:0];
  end

  // phase never reaches PERIOD; guard the index anyway
  assign weight = (32'(phase) < PERIOD) ? wtab[phase] : wtab[0];

endmodule

/* rtl/core/lcc_blend.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_blend
// One channel of the crossfade: c0 + floor((c1 - c0) * w / 256), mod 256.
// ----------------------------------------------------------------------------
module lcc_blend
  import lcc_pkg::*;
(
  input  logic [CH_W-1:0]     c0,
  input  logic [CH_W-1:0]     c1,
  input  logic [WEIGHT_W-1:0] weight,
  output logic [CH_W-1:0]     mixed
);

  logic signed [CH_W:0]              diff;
  logic signed [WEIGHT_W:0]          wgt_s;
  logic signed [CH_W+WEIGHT_W+1:0]   prod;
  logic signed [CH_W+WEIGHT_W+1:0]   prod_sh;

  // signed difference times weight, floor divide by 256
  always_comb begin
    diff    = $signed({1'b0, c1}) - $signed({1'b0, c0});
    wgt_s   = $signed({1'b0, weight});
    prod    = (CH_W+WEIGHT_W+2)'(diff) * (CH_W+WEIGHT_W+2)'(wgt_s);
    prod_sh = prod >>> WEIGHT_W;
    mixed   = c0 + prod_sh[CH_W-1:0];
  end

endmodule

/* rtl/core/led_color_crossfade_cycler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_color_crossfade_cycler
// Tick-driven palette crossfade with a raised-cosine weight per phase.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in_*      input      in_tvalid/in_tready    tick
//  out_*     output     out_tvalid/out_tready  red, green, blue, current_color
//  apb       input      psel/penable/pready    palette_color_0..5
//
//  one item per cycle while the output is not stalled; its result shows in
//  the output register in the cycle after accept. the path is state registers
//  -> weight table, palette mux, 8x8 multiply per channel -> output register.
//  reset (synchronous, rst_n low) clears phase, palette index, the first-period
//  flag and the output valid flag, and loads the default palette.
//  in_tready = !out_tvalid || out_tready: a held result stalls the input.
// ----------------------------------------------------------------------------
module led_color_crossfade_cycler
  import lcc_pkg::*;
#(
  parameter int PERIOD = 75
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] tick, [7:1] zero
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] red, [15:8] green, [23:16] blue,
                                  // [26:24] current_color, [31:27] zero
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PHASE_W = (PERIOD > 1) ? $clog2(PERIOD) : 1;

  // state
  logic [PHASE_W-1:0] phase_count_r;
  logic [CIDX_W-1:0]  color_index_r;
  logic               first_done_r;
  palette_t           palette_r;

  // output register
  logic               out_valid_r;
  logic [31:0]        out_data_r;

  // combinational values
  logic               in_accept;
  logic               tick;
  logic [CIDX_W-1:0]  cur_idx;
  logic [CIDX_W-1:0]  nxt_idx;
  logic [PHASE_W-1:0] phase_nxt;
  logic [WEIGHT_W-1:0] weight;
  rgb_t               c_from;
  rgb_t               c_to;
  rgb_t               mixed;
  logic [CIDX_W-1:0]  reg_idx;
  logic               cfg_write;

  // handshake
  assign in_tready  = !out_valid_r || out_tready;
  assign in_accept  = in_tvalid && in_tready;
  assign tick       = in_tdata[0];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // palette index and phase for this item
  always_comb begin
    if ((phase_count_r == '0) && first_done_r) begin
      cur_idx = step_index(color_index_r);
    end else begin
      cur_idx = color_index_r;
    end
    nxt_idx = step_index(cur_idx);
    if (phase_count_r >= PHASE_W'(PERIOD - 1)) begin
      phase_nxt = '0;
    end else begin
      phase_nxt = phase_count_r + PHASE_W'(1);
    end
    c_from = pick_color(palette_r, cur_idx);
    c_to   = pick_color(palette_r, nxt_idx);
  end

  lcc_weight_rom #(
    .PERIOD  (PERIOD),
    .PHASE_W (PHASE_W)
  ) u_weight_rom (
    .phase  (phase_count_r),
    .weight (weight)
  );

  lcc_blend u_blend_red (
    .c0     (c_from.red),
    .c1     (c_to.red),
    .weight (weight),
    .mixed  (mixed.red)
  );

  lcc_blend u_blend_green (
    .c0     (c_from.green),
    .c1     (c_to.green),
    .weight (weight),
    .mixed  (mixed.green)
  );

  lcc_blend u_blend_blue (
    .c0     (c_from.blue),
    .c1     (c_to.blue),
    .weight (weight),
    .mixed  (mixed.blue)
  );

  // fade state advances on a tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_count_r <= '0;
      color_index_r <= '0;
      first_done_r  <= 1'b0;
    end else if (in_accept && tick) begin
      phase_count_r <= phase_nxt;
      color_index_r <= cur_idx;
      first_done_r  <= 1'b1;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= {5'b0, cur_idx, mixed.blue, mixed.green, mixed.red};
    end
  end

  // register decode
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  // palette registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_r[0] <= PALETTE_RESET_0;
      palette_r[1] <= PALETTE_RESET_1;
      palette_r[2] <= PALETTE_RESET_2;
      palette_r[3] <= PALETTE_RESET_3;
      palette_r[4] <= PALETTE_RESET_4;
      palette_r[5] <= PALETTE_RESET_5;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_PALETTE_0: palette_r[0] <= pwdata[23:0];
        REG_PALETTE_1: palette_r[1] <= pwdata[23:0];
        REG_PALETTE_2: palette_r[2] <= pwdata[23:0];
        REG_PALETTE_3: palette_r[3] <= pwdata[23:0];
        REG_PALETTE_4: palette_r[4] <= pwdata[23:0];
        REG_PALETTE_5: palette_r[5] <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (reg_idx)
      REG_PALETTE_0: prdata = {8'b0, palette_r[0]};
      REG_PALETTE_1: prdata = {8'b0, palette_r[1]};
      REG_PALETTE_2: prdata = {8'b0, palette_r[2]};
      REG_PALETTE_3: prdata = {8'b0, palette_r[3]};
      REG_PALETTE_4: prdata = {8'b0, palette_r[4]};
      REG_PALETTE_5: prdata = {8'b0, palette_r[5]};
      default:       prdata = '0;
    endcase
  end

  // phase stays inside the period
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(phase_count_r) < PERIOD)
    else $error("phase counter left the period");

  // palette index stays inside the cycle
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(color_index_r) < COLOR_COUNT)
    else $error("palette index out of range");

  // an accepted item always leaves a result in the output register
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted item produced no result");

  // a tick moves the phase by one, with wrap
  a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && tick) |=> (phase_count_r == $past(phase_nxt)))
    else $error("phase did not step on a tick");

endmodule
